### hw/rtl/rx_l4_checksum_verify_defines.svh
// Assertion macros shared by the receive checksum verification block.
`ifndef RX_L4_CHECKSUM_VERIFY_DEFINES_SVH
`define RX_L4_CHECKSUM_VERIFY_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define RLCV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlcv: next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define RLCV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlcv: same-cycle check failed");

`endif

### hw/rtl/rlcv_pkg.sv
// Package with types, constants and the checksum fold for the checksum verifier.
`timescale 1ns / 1ps
`default_nettype none
package rlcv_pkg;

   localparam int HdrWordWidth = 64;
   localparam int LenWidth = 16;
   localparam int SumWidth = 32;

   localparam logic [3:0] VersionV4 = 4'd4;
   localparam logic [3:0] VersionV6 = 4'd6;
   localparam logic [7:0] V4FirstByte = 8'h45;
   localparam logic [7:0] FragMask = 8'h3f;
   localparam logic [7:0] ProtoTcp = 8'd6;
   localparam logic [7:0] ProtoUdp = 8'd17;
   localparam logic [15:0] V4HdrLen = 16'd20;
   localparam logic [15:0] V6HdrLen = 16'd40;
   localparam logic [15:0] UdpMinLen = 16'd8;
   localparam logic [15:0] TcpMinLen = 16'd20;
   localparam logic [15:0] SumGood = 16'hffff;

   typedef struct packed {
      logic v4_hdr_ok;
      logic v4_l4_ok;
      logic v6_l4_ok;
   } rlcv_sums_type;

   typedef struct packed {
      logic v4_ok;
      logic v6_ok;
   } rlcv_rules_type;

   // Folds a 32-bit ones-complement sum to 16 bits with end-around carry.
   function automatic logic [15:0] fold16(input logic [31:0] a);
      logic [16:0] s1;
      logic [16:0] s2;
      s1 = {1'b0, a[15:0]} + {1'b0, a[31:16]};
      s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
      return s2[15:0];
   endfunction

   // Transport length rules shared by both IP versions.
   function automatic logic l4_len_ok(input logic [7:0] proto, input logic [15:0] tlen,
                                      input logic [15:0] udp_len,
                                      input logic [15:0] udp_cks);
      logic ok;
      if (proto == ProtoUdp) begin
         ok = (tlen >= UdpMinLen) && (udp_len == tlen) && (udp_cks != 16'd0);
      end else begin
         ok = (tlen >= TcpMinLen);
      end
      return ok;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/rlcv_rules.sv
// Header rule checks for IPv4 and IPv6 requests.
`timescale 1ns / 1ps
`default_nettype none
module rlcv_rules (
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr0,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr3,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr5,
   input  wire logic [7:0]                        v4_proto,
   input  wire logic [rlcv_pkg::LenWidth-1:0]     packet_length,
   output rlcv_pkg::rlcv_rules_type               rules
);
   import rlcv_pkg::*;

   logic [15:0] v4_total;
   logic [15:0] v4_tlen;
   logic [15:0] v6_tlen;
   logic [15:0] v6_plen;
   logic [7:0]  v6_nh;

   assign v4_total = hdr0[47:32];
   assign v4_tlen = v4_total - V4HdrLen;
   assign v6_tlen = hdr0[31:16];
   assign v6_plen = v6_tlen + V6HdrLen;
   assign v6_nh = hdr0[15:8];

   always_comb begin
      rules.v4_ok = (hdr0[63:56] == V4FirstByte)
         && (v4_total == packet_length) && (v4_total >= V4HdrLen)
         && ((hdr0[15:8] & FragMask) == 8'd0) && (hdr0[7:0] == 8'd0)
         && ((v4_proto == ProtoTcp) || (v4_proto == ProtoUdp))
         && l4_len_ok(v4_proto, v4_tlen, hdr3[63:48], hdr3[47:32]);
      rules.v6_ok = (v6_plen == packet_length)
         && ((v6_nh == ProtoTcp) || (v6_nh == ProtoUdp))
         && l4_len_ok(v6_nh, v6_tlen, hdr5[31:16], hdr5[15:0]);
   end

endmodule
`default_nettype wire

### hw/rtl/rlcv_sums.sv
// Ones-complement header and pseudo-header checksum evaluation.
`timescale 1ns / 1ps
`default_nettype none
module rlcv_sums (
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr0,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr1,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0] hdr2,
   input  wire logic [rlcv_pkg::SumWidth-1:0]     copy_sum,
   output rlcv_pkg::rlcv_sums_type                sums
);
   import rlcv_pkg::*;

   logic [31:0] v4_hdr_acc;
   logic [31:0] v4_pseudo_acc;
   logic [31:0] v6_fixed_acc;
   logic [31:0] v6_pseudo_acc;
   logic [15:0] copy_fold;
   logic [15:0] v6_fixed;
   logic [15:0] v4_tlen;
   logic [7:0]  v4_proto;

   assign v4_proto = hdr1[55:48];
   assign v4_tlen = hdr0[47:32] - V4HdrLen;
   assign copy_fold = fold16(copy_sum);

   always_comb begin
      v4_hdr_acc = {16'd0, hdr0[63:48]} + {16'd0, hdr0[47:32]} + {16'd0, hdr0[31:16]}
         + {16'd0, hdr0[15:0]} + {16'd0, hdr1[63:48]} + {16'd0, hdr1[47:32]}
         + {16'd0, hdr1[31:16]} + {16'd0, hdr1[15:0]} + {16'd0, hdr2[63:48]}
         + {16'd0, hdr2[47:32]};
      v4_pseudo_acc = {16'd0, copy_fold} + {16'd0, hdr1[31:16]} + {16'd0, hdr1[15:0]}
         + {16'd0, hdr2[63:48]} + {16'd0, hdr2[47:32]} + {24'd0, v4_proto}
         + {16'd0, v4_tlen};
      v6_fixed_acc = {16'd0, hdr0[63:48]} + {16'd0, hdr0[47:32]} + {16'd0, hdr0[31:16]}
         + {16'd0, hdr0[15:0]};
      v6_fixed = fold16(v6_fixed_acc);
      v6_pseudo_acc = {16'd0, copy_fold} + {16'd0, ~v6_fixed} + {16'd0, hdr0[31:16]}
         + {24'd0, hdr0[15:8]};
      sums.v4_hdr_ok = (fold16(v4_hdr_acc) == SumGood);
      sums.v4_l4_ok = (fold16(v4_pseudo_acc) == SumGood);
      sums.v6_l4_ok = (fold16(v6_pseudo_acc) == SumGood);
   end

endmodule
`default_nettype wire

### hw/rtl/rx_l4_checksum_verify.sv
// Top level of the receive-side TCP/UDP checksum verifier.
// An accepted request is captured in the request register, and its strobed result comes from the result register.
// Throughput: one request per cycle; busy is never raised, so start may stay high.
// The rule and checksum logic sits between the request register and the result register.
// Reset clears both valid flags; payload registers are not reset.
// The receiver cannot stall, so each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "rx_l4_checksum_verify_defines.svh"
module rx_l4_checksum_verify (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_0_7,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_8_15,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_16_23,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_24_31,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_32_39,
   input  wire logic [rlcv_pkg::HdrWordWidth-1:0]   req_hdr_bytes_40_47,
   input  wire logic [rlcv_pkg::LenWidth-1:0]       req_packet_length,
   input  wire logic [rlcv_pkg::SumWidth-1:0]       req_copy_sum,
   output logic                                     rsp_valid,
   output logic                                     rsp_verified
);
   import rlcv_pkg::*;

   logic                    req_valid_ff;
   logic                    req_valid_in;
   logic [HdrWordWidth-1:0] hdr0_ff;
   logic [HdrWordWidth-1:0] hdr1_ff;
   logic [HdrWordWidth-1:0] hdr2_ff;
   logic [HdrWordWidth-1:0] hdr3_ff;
   logic [HdrWordWidth-1:0] hdr5_ff;
   logic [LenWidth-1:0]     plen_ff;
   logic [SumWidth-1:0]     sum_ff;
   logic                    rsp_valid_ff;
   logic                    rsp_verified_ff;
   logic                    rsp_verified_in;
   logic                    accept;
   logic [3:0]              version;
   rlcv_rules_type          rules;
   rlcv_sums_type           sums;

   assign busy = 1'b0;
   assign accept = start && !busy;
   assign req_valid_in = accept;

   // Bytes 32..39 hold nothing this check needs, so they are not stored.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hdr0_ff <= req_hdr_bytes_0_7;
         hdr1_ff <= req_hdr_bytes_8_15;
         hdr2_ff <= req_hdr_bytes_16_23;
         hdr3_ff <= req_hdr_bytes_24_31;
         hdr5_ff <= req_hdr_bytes_40_47;
         plen_ff <= req_packet_length;
         sum_ff <= req_copy_sum;
      end
      rsp_verified_ff <= rsp_verified_in;
   end

   rlcv_rules u_rules (
      .hdr0          (hdr0_ff),
      .hdr3          (hdr3_ff),
      .hdr5          (hdr5_ff),
      .v4_proto      (hdr1_ff[55:48]),
      .packet_length (plen_ff),
      .rules         (rules)
   );

   rlcv_sums u_sums (
      .hdr0     (hdr0_ff),
      .hdr1     (hdr1_ff),
      .hdr2     (hdr2_ff),
      .copy_sum (sum_ff),
      .sums     (sums)
   );

   assign version = hdr0_ff[63:60];

   always_comb begin
      rsp_verified_in = 1'b0;
      if (plen_ff != '0) begin
         if (version == VersionV4) begin
            rsp_verified_in = rules.v4_ok && sums.v4_hdr_ok && sums.v4_l4_ok;
         end else if (version == VersionV6) begin
            rsp_verified_in = rules.v6_ok && sums.v6_l4_ok;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_verified = rsp_verified_ff;

   `RLCV_ASSERT_NEXT(a_accept_to_stage, clock, reset, accept, req_valid_ff)
   `RLCV_ASSERT_NEXT(a_stage_to_result, clock, reset, req_valid_ff, rsp_valid)
   `RLCV_ASSERT_NEXT(a_no_spurious_result, clock, reset, !req_valid_ff, !rsp_valid)
   `RLCV_ASSERT_NOW(a_zero_length_fails, clock, reset,
      rsp_valid && ($past(plen_ff) == '0), !rsp_verified)

endmodule
`default_nettype wire

### tb/sv/rx_l4_checksum_verify_test.sv
// Self-checking testbench for the receive-side TCP/UDP checksum verifier.
`timescale 1ns / 1ps

module rx_l4_checksum_verify_test;
   import rlcv_pkg::*;

   localparam int CycleLimit = 200000;
   localparam int RandomPerPhase = 488;
   localparam int DrainCycles = 8;
   localparam logic [7:0] ProtoIcmp = 8'd1;
   localparam logic [7:0] ProtoHopByHop = 8'd0;

   typedef struct {
      logic [383:0] hdr;
      logic [15:0] plen;
      logic [31:0] sum;
   } checksum_request_type;

   function automatic logic [15:0] fold_ones(logic [31:0] a);
      logic [31:0] t;
      t = {16'd0, a[15:0]} + {16'd0, a[31:16]};
      t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
      return t[15:0];
   endfunction

   function automatic logic [7:0] byte_at(logic [383:0] h, int k);
      return h[383 - 8 * k -: 8];
   endfunction

   function automatic logic [15:0] word_at(logic [383:0] h, int k);
      return h[383 - 8 * k -: 16];
   endfunction

   class verdict_tracker;
      bit expected_verdicts[$];
      int unsigned mismatches;
      int unsigned results_seen;

      static function bit transport_ok(logic [383:0] h, logic [7:0] proto, logic [15:0] tlen,
                                       int l4);
         if (proto == ProtoUdp) begin
            return tlen >= UdpMinLen && word_at(h, l4 + 4) == tlen
                   && word_at(h, l4 + 6) != 16'd0;
         end
         return tlen >= TcpMinLen;
      endfunction

      static function bit predict_verdict(logic [383:0] h, logic [15:0] plen,
                                          logic [31:0] sum);
         logic [31:0] acc;
         logic [15:0] total;
         logic [15:0] tlen;
         logic [15:0] wrapped;
         logic [15:0] inv_fixed;
         logic [7:0] first;
         logic [7:0] proto;
         int i;
         first = byte_at(h, 0);
         if (plen == 16'd0) begin
            return 1'b0;
         end
         if (first[7:4] == VersionV4) begin
            if (first != V4FirstByte) begin
               return 1'b0;
            end
            total = word_at(h, 2);
            if (total != plen || total < V4HdrLen) begin
               return 1'b0;
            end
            if ((byte_at(h, 6) & FragMask) != 8'd0 || byte_at(h, 7) != 8'd0) begin
               return 1'b0;
            end
            proto = byte_at(h, 9);
            if (proto != ProtoTcp && proto != ProtoUdp) begin
               return 1'b0;
            end
            acc = 32'd0;
            for (i = 0; i < 20; i += 2) begin
               acc += word_at(h, i);
            end
            if (fold_ones(acc) != SumGood) begin
               return 1'b0;
            end
            tlen = total - V4HdrLen;
            if (!transport_ok(h, proto, tlen, 20)) begin
               return 1'b0;
            end
            acc = fold_ones(sum) + word_at(h, 12) + word_at(h, 14) + word_at(h, 16)
                  + word_at(h, 18) + proto + tlen;
            return fold_ones(acc) == SumGood;
         end else if (first[7:4] == VersionV6) begin
            tlen = word_at(h, 4);
            wrapped = tlen + V6HdrLen;
            if (wrapped != plen) begin
               return 1'b0;
            end
            proto = byte_at(h, 6);
            if (proto != ProtoTcp && proto != ProtoUdp) begin
               return 1'b0;
            end
            if (!transport_ok(h, proto, tlen, 40)) begin
               return 1'b0;
            end
            acc = word_at(h, 0) + word_at(h, 2) + word_at(h, 4) + word_at(h, 6);
            inv_fixed = ~fold_ones(acc);
            acc = fold_ones(sum) + inv_fixed + tlen + proto;
            return fold_ones(acc) == SumGood;
         end
         return 1'b0;
      endfunction

      function void note_request(logic [383:0] h, logic [15:0] plen, logic [31:0] sum);
         expected_verdicts.push_back(predict_verdict(h, plen, sum));
      endfunction

      function void check_result(logic got);
         bit want;
         results_seen++;
         if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d: verified=%b with no request outstanding",
                        results_seen, got);
            end
            return;
         end
         want = expected_verdicts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result %0d: verified expected %b, got %b", results_seen, want, got);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [63:0] req_hdr_bytes_0_7 = '0;
   logic [63:0] req_hdr_bytes_8_15 = '0;
   logic [63:0] req_hdr_bytes_16_23 = '0;
   logic [63:0] req_hdr_bytes_24_31 = '0;
   logic [63:0] req_hdr_bytes_32_39 = '0;
   logic [63:0] req_hdr_bytes_40_47 = '0;
   logic [15:0] req_packet_length = '0;
   logic [31:0] req_copy_sum = '0;
   logic rsp_valid;
   logic rsp_verified;

   verdict_tracker verdicts = new;
   int idle_pct = 0;
   int unsigned cycle_count = 0;
   int phase_idle[4] = '{0, 60, 0, 35};

   rx_l4_checksum_verify dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_hdr_bytes_0_7(req_hdr_bytes_0_7),
      .req_hdr_bytes_8_15(req_hdr_bytes_8_15),
      .req_hdr_bytes_16_23(req_hdr_bytes_16_23),
      .req_hdr_bytes_24_31(req_hdr_bytes_24_31),
      .req_hdr_bytes_32_39(req_hdr_bytes_32_39),
      .req_hdr_bytes_40_47(req_hdr_bytes_40_47),
      .req_packet_length(req_packet_length),
      .req_copy_sum(req_copy_sum),
      .rsp_valid(rsp_valid),
      .rsp_verified(rsp_verified)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("rx_l4_checksum_verify_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            verdicts.check_result(rsp_verified);
         end
         if (start && !busy) begin
            verdicts.note_request({req_hdr_bytes_0_7, req_hdr_bytes_8_15, req_hdr_bytes_16_23,
                                   req_hdr_bytes_24_31, req_hdr_bytes_32_39,
                                   req_hdr_bytes_40_47}, req_packet_length, req_copy_sum);
         end
      end
   end

   function automatic logic [383:0] with_byte(logic [383:0] h, int k, logic [7:0] v);
      h[383 - 8 * k -: 8] = v;
      return h;
   endfunction

   function automatic logic [383:0] with_word(logic [383:0] h, int k, logic [15:0] v);
      h[383 - 8 * k -: 16] = v;
      return h;
   endfunction

   function automatic checksum_request_type fresh_packet(bit v6, logic [7:0] proto,
                                                         logic [15:0] tlen);
      checksum_request_type p;
      int l4;
      for (int i = 0; i < 12; i++) begin
         p.hdr[32 * i +: 32] = $urandom();
      end
      if (!v6) begin
         l4 = 20;
         p.hdr = with_byte(p.hdr, 0, V4FirstByte);
         p.hdr = with_word(p.hdr, 2, tlen + V4HdrLen);
         p.hdr = with_byte(p.hdr, 6, byte_at(p.hdr, 6) & ~FragMask);
         p.hdr = with_byte(p.hdr, 7, 8'd0);
         p.hdr = with_byte(p.hdr, 9, proto);
         p.plen = tlen + V4HdrLen;
      end else begin
         l4 = 40;
         p.hdr[383:380] = VersionV6;
         p.hdr = with_word(p.hdr, 4, tlen);
         p.hdr = with_byte(p.hdr, 6, proto);
         p.plen = tlen + V6HdrLen;
      end
      if (proto == ProtoUdp) begin
         p.hdr = with_word(p.hdr, l4 + 4, tlen);
         p.hdr = with_word(p.hdr, l4 + 6, 16'($urandom_range(65535, 1)));
      end
      p.sum = $urandom();
      return p;
   endfunction

   // Fills in the IPv4 header checksum and picks a copy sum that makes the
   // transport checksum come out right for whatever the header now says.
   function automatic checksum_request_type seal(checksum_request_type p);
      logic [31:0] acc;
      logic [15:0] cks;
      logic [15:0] tlen;
      logic [15:0] target;
      logic [15:0] high;
      int i;
      if (p.hdr[383:380] == VersionV4) begin
         p.hdr = with_word(p.hdr, 10, 16'd0);
         acc = 32'd0;
         for (i = 0; i < 20; i += 2) begin
            acc += word_at(p.hdr, i);
         end
         cks = ~fold_ones(acc);
         p.hdr = with_word(p.hdr, 10, cks);
         tlen = word_at(p.hdr, 2) - V4HdrLen;
         acc = word_at(p.hdr, 12) + word_at(p.hdr, 14) + word_at(p.hdr, 16)
               + word_at(p.hdr, 18) + byte_at(p.hdr, 9) + tlen;
      end else begin
         acc = word_at(p.hdr, 0) + word_at(p.hdr, 2) + word_at(p.hdr, 4) + word_at(p.hdr, 6);
         cks = ~fold_ones(acc);
         acc = cks + word_at(p.hdr, 4) + byte_at(p.hdr, 6);
      end
      target = ~fold_ones(acc);
      if (target == 16'd0) begin
         target = 16'hffff;
      end
      high = 16'($urandom());
      p.sum = {high, fold_ones({16'd0, target} + {16'd0, ~high})};
      return p;
   endfunction

   task automatic send_request(checksum_request_type p);
      req_hdr_bytes_0_7 <= p.hdr[383:320];
      req_hdr_bytes_8_15 <= p.hdr[319:256];
      req_hdr_bytes_16_23 <= p.hdr[255:192];
      req_hdr_bytes_24_31 <= p.hdr[191:128];
      req_hdr_bytes_32_39 <= p.hdr[127:64];
      req_hdr_bytes_40_47 <= p.hdr[63:0];
      req_packet_length <= p.plen;
      req_copy_sum <= p.sum;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic directed_requests();
      checksum_request_type p;
      p = '{hdr: '0, plen: '0, sum: '0};
      send_request(p);
      p = '{hdr: '1, plen: '1, sum: '1};
      send_request(p);
      send_request(seal(fresh_packet(1'b0, ProtoUdp, UdpMinLen)));
      send_request(seal(fresh_packet(1'b0, ProtoTcp, TcpMinLen)));
      send_request(seal(fresh_packet(1'b0, ProtoUdp, 16'd65515)));
      send_request(seal(fresh_packet(1'b0, ProtoTcp, TcpMinLen - 16'd1)));
      send_request(seal(fresh_packet(1'b0, ProtoUdp, UdpMinLen - 16'd1)));
      p = fresh_packet(1'b0, ProtoUdp, 16'd100);
      p.hdr = with_word(p.hdr, 26, 16'd0);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoUdp, 16'd100);
      p.hdr = with_word(p.hdr, 24, 16'd101);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoTcp, 16'd60);
      p.hdr = with_byte(p.hdr, 0, V4FirstByte + 8'd1);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoTcp, 16'd60);
      p.hdr = with_byte(p.hdr, 6, 8'h20);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoTcp, 16'd60);
      p.hdr = with_byte(p.hdr, 7, 8'h01);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoTcp, 16'd60);
      p.hdr = with_byte(p.hdr, 6, ~FragMask);
      send_request(seal(p));
      send_request(seal(fresh_packet(1'b0, ProtoIcmp, 16'd60)));
      p = seal(fresh_packet(1'b0, ProtoUdp, 16'd64));
      p.hdr = with_word(p.hdr, 10, word_at(p.hdr, 10) ^ 16'h0001);
      send_request(p);
      p = seal(fresh_packet(1'b0, ProtoTcp, 16'd64));
      p.plen = p.plen + 16'd1;
      send_request(p);
      p = seal(fresh_packet(1'b0, ProtoTcp, 16'd64));
      p.sum = p.sum + 32'd1;
      send_request(p);
      p = fresh_packet(1'b0, ProtoTcp, 16'd0);
      p.hdr = with_word(p.hdr, 2, V4HdrLen - 16'd1);
      p.plen = V4HdrLen - 16'd1;
      send_request(seal(p));
      send_request(seal(fresh_packet(1'b1, ProtoUdp, UdpMinLen)));
      send_request(seal(fresh_packet(1'b1, ProtoTcp, TcpMinLen)));
      send_request(seal(fresh_packet(1'b1, ProtoHopByHop, 16'd64)));
      send_request(seal(fresh_packet(1'b1, ProtoTcp, 16'd65496)));
      send_request(seal(fresh_packet(1'b1, ProtoTcp, 16'd65535)));
      p = fresh_packet(1'b1, ProtoUdp, 16'd64);
      p.hdr = with_word(p.hdr, 46, 16'd0);
      send_request(seal(p));
      p = fresh_packet(1'b0, ProtoTcp, 16'd60);
      p.hdr[383:380] = 4'd5;
      send_request(seal(p));
   endtask

   task automatic random_request();
      checksum_request_type p;
      int pick;
      int bit_pos;
      bit v6;
      logic [7:0] proto;
      logic [15:0] tlen;
      logic [15:0] min_len;
      pick = $urandom_range(99);
      if (pick < 10) begin
         for (int i = 0; i < 12; i++) begin
            p.hdr[32 * i +: 32] = $urandom();
         end
         p.plen = 16'($urandom());
         p.sum = $urandom();
      end else begin
         v6 = ($urandom_range(1) == 1);
         proto = $urandom_range(1) ? ProtoUdp : ProtoTcp;
         min_len = (proto == ProtoUdp) ? UdpMinLen : TcpMinLen;
         if ($urandom_range(3) == 0) begin
            tlen = 16'($urandom_range(v6 ? 65535 : 65515, min_len));
         end else begin
            tlen = 16'($urandom_range(1500, min_len));
         end
         p = seal(fresh_packet(v6, proto, tlen));
         if (pick < 35) begin
            case ($urandom_range(2))
               0: begin
                  bit_pos = $urandom_range(383);
                  p.hdr[bit_pos] = ~p.hdr[bit_pos];
               end
               1: begin
                  bit_pos = $urandom_range(15);
                  p.plen[bit_pos] = ~p.plen[bit_pos];
               end
               default: begin
                  bit_pos = $urandom_range(31);
                  p.sum[bit_pos] = ~p.sum[bit_pos];
               end
            endcase
            if ($urandom_range(1) == 1) begin
               p = seal(p);
            end
         end
      end
      send_request(p);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_requests();
      foreach (phase_idle[ph]) begin
         idle_pct = phase_idle[ph];
         repeat (RandomPerPhase) random_request();
      end
      start <= 1'b0;
      while (verdicts.expected_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (verdicts.mismatches == 0 && verdicts.expected_verdicts.size() == 0) begin
         $display("rx_l4_checksum_verify_test OK");
      end else begin
         $display("rx_l4_checksum_verify_test NOT OK");
      end
      $finish;
   end

endmodule
